// ===== rtl/core/huffman_stream_decoder_defines.svh =====
// Assertion macros shared by the Huffman stream decoder RTL.
// Depends on nothing; each user module must have clk and arst_n in scope.
`ifndef HUFFMAN_STREAM_DECODER_DEFINES_SVH
`define HUFFMAN_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define HSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsd check failed");

// Next-cycle implication, checked out of reset
`define HSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsd check failed");

`endif

// ===== rtl/core/hsd_pkg.sv =====
// Shared types and constants for the Huffman stream decoder.
// No dependencies.
`default_nettype none
package hsd_pkg;

	localparam int KEY_W = 8;

	// Decoder phase codes
	typedef enum logic [1:0] {
		PH_SHAPE  = 2'd0,
		PH_KEYS   = 2'd1,
		PH_PREFIX = 2'd2,
		PH_DATA   = 2'd3
	} hsd_phase_t;

	// Request from the sequencer to the result stage
	typedef struct packed {
		logic             push;
		logic             flush;
		logic [KEY_W-1:0] sym;
		logic             err;
	} hsd_emit_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/hsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/hsd_emit.sv =====
// Result stage: one held result plus the output register, so that the last
// result of a byte can be marked. Depends on hsd_pkg and the defines header.
`default_nettype none
`include "huffman_stream_decoder_defines.svh"
module hsd_emit
	import hsd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hsd_emit_req_t    req,
	output logic                  ok,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [KEY_W-1:0] out_symbol,
	output logic                  last_of_run,
	output logic                  tree_error
);

	logic             pend_v_q;
	logic [KEY_W-1:0] pend_sym_q;
	logic             pend_err_q;
	logic             out_v_q;
	logic             out_free;
	logic             move;

	assign out_free = !out_v_q || out_ready;
	assign ok       = !pend_v_q || out_free;
	assign move     = pend_v_q && out_free && (req.push || req.flush);

	// Hold the newest result until the next one or the end of the byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (ok && req.push) begin
			pend_v_q <= 1'b1;
		end else if (ok && req.flush) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ok && req.push) begin
			pend_sym_q <= req.sym;
			pend_err_q <= req.err;
		end
	end

	// Advance the held result into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_symbol  <= pend_sym_q;
			tree_error  <= pend_err_q;
			last_of_run <= req.flush;
		end
	end

	assign out_valid = out_v_q;

	`HSD_ASSERT_IMP(a_push_flush_excl, req.push, !req.flush)
	`HSD_ASSERT_NXT(a_push_moves, req.push && pend_v_q && out_free, out_v_q && !last_of_run)
	`HSD_ASSERT_NXT(a_flush_marks_last, req.flush && pend_v_q && out_free, out_v_q && last_of_run)

endmodule
`default_nettype wire

// ===== rtl/core/huffman_stream_decoder.sv =====
// A shape byte classifies one tree node per bit, a key byte writes at most one leaf key,
// a byte after an error is only flushed, and a data byte does one node-memory lookup
// per data bit unless the root is a leaf. Not ready while a byte is worked.
// Results leave through a registered output; output stalls extend the byte.
// Reset (arst_n, asynchronous, active low) clears control state; the node
// and leaf memories are not cleared and need no clearing pass.
`default_nettype none
`include "huffman_stream_decoder_defines.svh"
module huffman_stream_decoder
	import hsd_pkg::*;
#(
	parameter int TREE_NODES = 512,
	parameter int MAX_LEAVES = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [KEY_W-1:0] in_byte,
	input  wire logic             end_of_stream,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [KEY_W-1:0] out_symbol,
	output logic                  last_of_run,
	output logic                  tree_error
);

	localparam int NW = $clog2(TREE_NODES);
	localparam int LW = $clog2(MAX_LEAVES);
	localparam int EW = 1 + NW + KEY_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SHAPE = 7'b0000010,
		S_KEYRD = 7'b0000100,
		S_KEYWR = 7'b0001000,
		S_BIT   = 7'b0010000,
		S_EVAL  = 7'b0100000,
		S_FLUSH = 7'b1000000
	} hsd_state_t;

	hsd_state_t       state_q;
	hsd_phase_t       phase_q;
	logic [KEY_W-1:0] byte_q;
	logic             eos_q;
	logic [2:0]       bit_q;
	logic [NW:0]      alloc_q;
	logic [NW:0]      classify_q;
	logic [LW:0]      leaves_q;
	logic [LW:0]      keys_q;
	logic [NW-1:0]    cur_left_q;
	logic             err_q;
	logic             root_leaf_q;
	logic [KEY_W-1:0] root_key_q;

	logic             cur_bit;
	logic [NW+1:0]    alloc_plus2;
	logic             node_ovf;
	logic             leaf_ovf;
	logic [NW:0]      alloc_after;
	logic [NW:0]      classify_next;
	logic             shape_done;
	logic             emit_ok;
	hsd_emit_req_t    emit_req;

	logic             node_we;
	logic [NW-1:0]    node_waddr;
	logic [EW-1:0]    node_wdata;
	logic             node_re;
	logic [NW-1:0]    node_raddr;
	logic [EW-1:0]    node_rdata;
	logic             leaf_we;
	logic             leaf_re;
	logic [NW-1:0]    leaf_rdata;

	assign cur_bit       = byte_q[bit_q];
	assign alloc_plus2   = {1'b0, alloc_q} + (NW+2)'(2);
	assign node_ovf      = alloc_plus2 > (NW+2)'(TREE_NODES);
	assign leaf_ovf      = leaves_q >= (LW+1)'(MAX_LEAVES);
	assign alloc_after   = cur_bit ? alloc_q : alloc_plus2[NW:0];
	assign classify_next = classify_q + (NW+1)'(1);
	assign shape_done    = classify_next >= alloc_after;
	assign in_ready      = (state_q == S_IDLE);

	// Memory and result-stage controls for the current step
	always_comb begin
		node_we    = 1'b0;
		node_waddr = classify_q[NW-1:0];
		node_wdata = {1'b1, {NW{1'b0}}, {KEY_W{1'b0}}};
		node_re    = 1'b0;
		node_raddr = cur_left_q + NW'(cur_bit);
		leaf_we    = 1'b0;
		leaf_re    = 1'b0;
		emit_req   = '0;
		case (state_q)
			S_SHAPE: begin
				if (cur_bit ? leaf_ovf : node_ovf) begin
					emit_req.push = 1'b1;
					emit_req.err  = 1'b1;
				end else begin
					node_we = 1'b1;
					leaf_we = cur_bit;
					if (!cur_bit) begin
						node_wdata = {1'b0, alloc_q[NW-1:0], {KEY_W{1'b0}}};
					end
				end
			end
			S_KEYRD: begin
				leaf_re = 1'b1;
			end
			S_KEYWR: begin
				node_we    = 1'b1;
				node_waddr = leaf_rdata;
				node_wdata = {1'b1, {NW{1'b0}}, byte_q};
			end
			S_BIT: begin
				if (phase_q == PH_DATA) begin
					if (root_leaf_q) begin
						emit_req.push = 1'b1;
						emit_req.sym  = root_key_q;
					end else begin
						node_re = 1'b1;
					end
				end
			end
			S_EVAL: begin
				if (node_rdata[EW-1]) begin
					emit_req.push = 1'b1;
					emit_req.sym  = node_rdata[KEY_W-1:0];
				end
			end
			S_FLUSH: begin
				emit_req.flush = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: one shape, prefix or data bit per step, and a key byte as a whole
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SHAPE;
			alloc_q     <= (NW+1)'(1);
			classify_q  <= '0;
			leaves_q    <= '0;
			keys_q      <= '0;
			cur_left_q  <= NW'(1);
			err_q       <= 1'b0;
			root_leaf_q <= 1'b0;
			root_key_q  <= '0;
			byte_q      <= '0;
			eos_q       <= 1'b0;
			bit_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q <= in_byte;
						eos_q  <= end_of_stream;
						bit_q  <= 3'd7;
						if (err_q) begin
							state_q <= S_FLUSH;
						end else begin
							case (phase_q)
								PH_SHAPE: state_q <= S_SHAPE;
								PH_KEYS: begin
									if (keys_q < leaves_q) begin
										state_q <= S_KEYRD;
									end else begin
										phase_q <= PH_PREFIX;
										state_q <= S_FLUSH;
									end
								end
								default: state_q <= S_BIT;
							endcase
						end
					end
				end
				S_SHAPE: begin
					if (cur_bit ? leaf_ovf : node_ovf) begin
						// Drop the rest of the byte and stick on error
						if (emit_ok) begin
							err_q   <= 1'b1;
							state_q <= S_FLUSH;
						end
					end else begin
						alloc_q    <= alloc_after;
						classify_q <= classify_next;
						if (cur_bit) begin
							leaves_q <= leaves_q + (LW+1)'(1);
						end
						if (classify_q == '0) begin
							root_leaf_q <= cur_bit;
						end
						if (shape_done) begin
							phase_q <= PH_KEYS;
							state_q <= S_FLUSH;
						end else if (bit_q == 3'd0) begin
							state_q <= S_FLUSH;
						end else begin
							bit_q <= bit_q - 3'd1;
						end
					end
				end
				S_KEYRD: begin
					state_q <= S_KEYWR;
				end
				S_KEYWR: begin
					keys_q <= keys_q + (LW+1)'(1);
					if (leaf_rdata == '0) begin
						root_key_q <= byte_q;
					end
					if (keys_q + (LW+1)'(1) >= leaves_q) begin
						phase_q <= PH_PREFIX;
					end
					state_q <= S_FLUSH;
				end
				S_BIT: begin
					if (phase_q == PH_PREFIX || root_leaf_q) begin
						if (phase_q == PH_PREFIX || emit_ok) begin
							if (phase_q == PH_PREFIX && cur_bit) begin
								phase_q <= PH_DATA;
							end
							if (bit_q == 3'd0) begin
								state_q <= S_FLUSH;
							end else begin
								bit_q <= bit_q - 3'd1;
							end
						end
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!node_rdata[EW-1] || emit_ok) begin
						// Back to the root on a leaf, else descend
						cur_left_q <= node_rdata[EW-1] ? NW'(1) : node_rdata[EW-2 -: NW];
						if (bit_q == 3'd0) begin
							state_q <= S_FLUSH;
						end else begin
							bit_q   <= bit_q - 3'd1;
							state_q <= S_BIT;
						end
					end
				end
				S_FLUSH: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
						if (eos_q) begin
							phase_q    <= PH_SHAPE;
							alloc_q    <= (NW+1)'(1);
							classify_q <= '0;
							leaves_q   <= '0;
							keys_q     <= '0;
							cur_left_q <= NW'(1);
							err_q      <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	hsd_ram #(
		.WIDTH(EW),
		.DEPTH(TREE_NODES)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.re   (node_re),
		.raddr(node_raddr),
		.rdata(node_rdata)
	);

	hsd_ram #(
		.WIDTH(NW),
		.DEPTH(MAX_LEAVES)
	) u_leaf_ram (
		.clk  (clk),
		.we   (leaf_we),
		.waddr(leaves_q[LW-1:0]),
		.wdata(classify_q[NW-1:0]),
		.re   (leaf_re),
		.raddr(keys_q[LW-1:0]),
		.rdata(leaf_rdata)
	);

	hsd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (emit_req),
		.ok         (emit_ok),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_symbol (out_symbol),
		.last_of_run(last_of_run),
		.tree_error (tree_error)
	);

	`HSD_ASSERT_IMP(a_err_in_shape, err_q, phase_q == PH_SHAPE)
	`HSD_ASSERT_IMP(a_classify_bound, 1'b1, classify_q <= alloc_q)
	`HSD_ASSERT_IMP(a_keys_bound, 1'b1, keys_q <= leaves_q)

endmodule
`default_nettype wire
